@@ sv/als_pkg.sv @@
package als_pkg;

  // Grid geometry
  localparam int GRID_SIZE = 128;
  localparam int POS_W     = $clog2(GRID_SIZE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(GRID_SIZE - 1);
  localparam logic [POS_W-1:0] POS_TWO  = POS_W'(2);

  // Field widths
  localparam int CELL_W    = 8;
  localparam int OUT_POS_W = 7;
  localparam int MASK_W    = 9;
  localparam int NCNT_W    = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_BIRTH_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURVIVE_MASK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LIVE_VALUE   = 2'd2;
  localparam logic [MASK_W-1:0] BIRTH_MASK_RST   = 9'd72;
  localparam logic [MASK_W-1:0] SURVIVE_MASK_RST = 9'd12;
  localparam logic [CELL_W-1:0] LIVE_VALUE_RST   = 8'd4;

  // Result queue
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [MASK_W-1:0] birth_mask;
    logic [MASK_W-1:0] survive_mask;
    logic [CELL_W-1:0] live_value;
  } cfg_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic [CELL_W-1:0]    value;
    logic                 last;
  } res_t;

  // Up to two results per cell, first in slot a
  typedef struct packed {
    logic [1:0] n;
    res_t       a;
    res_t       b;
  } push_t;

  function automatic logic [OUT_POS_W-1:0] pos_out(input logic [POS_W-1:0] p);
    return OUT_POS_W'(p);
  endfunction

endpackage

@@ sv/als_ram.sv @@
module als_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Registered read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

endmodule

@@ sv/als_front.sv @@
module als_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  als_pkg::cfg_t                cfg,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [als_pkg::CELL_W-1:0]   in_cell_value,
  input  logic                         in_frame_start,
  input  logic                         q_room,
  output als_pkg::push_t               push
);

  logic                        accept;
  logic                        s1_fire;
  logic [als_pkg::POS_W-1:0]   row_cur, col_cur;
  logic [als_pkg::POS_W-1:0]   row_r, row_nxt, col_r, col_nxt;
  logic                        s1_valid_r, s1_valid_nxt;
  logic [als_pkg::POS_W-1:0]   s1_row_r, s1_col_r;
  logic [als_pkg::CELL_W-1:0]  s1_cell_r;
  logic [als_pkg::CELL_W-1:0]  top_ram, mid_ram, top, mid;
  logic                        fwd_r;
  logic [als_pkg::CELL_W-1:0]  fwd_data_r;
  logic [als_pkg::CELL_W-1:0]  win_r [6];
  logic [als_pkg::CELL_W-1:0]  neigh [8];
  logic [als_pkg::NCNT_W-1:0]  ncnt;
  logic [als_pkg::CELL_W-1:0]  centre, new_val;
  logic                        interior, border;
  als_pkg::res_t               res_int, res_bord;

  assign s1_fire = s1_valid_r && q_room;
  assign in_full = s1_valid_r && !q_room;
  assign accept  = in_push && !in_full;

  // Position of the incoming cell
  assign row_cur = in_frame_start ? '0 : row_r;
  assign col_cur = in_frame_start ? '0 : col_r;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_cur == als_pkg::POS_LAST) begin
        col_nxt = '0;
        row_nxt = (row_cur == als_pkg::POS_LAST) ? '0 : row_cur + 1'b1;
      end else begin
        col_nxt = col_cur + 1'b1;
        row_nxt = row_cur;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        fwd_r <= s1_fire && (s1_col_r == col_cur);
      end else if (s1_fire) begin
        fwd_r <= 1'b0;
      end
    end
  end

  // Hold the accepted cell while its line words are read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row_r   <= row_cur;
      s1_col_r   <= col_cur;
      s1_cell_r  <= in_cell_value;
      fwd_data_r <= mid;
    end
  end

  // Row above: read and overwritten with the new cell on accept
  als_ram #(.WIDTH(als_pkg::CELL_W), .DEPTH(als_pkg::GRID_SIZE)) u_newer_line (
    .clk   (clk),
    .we    (accept),
    .waddr (col_cur),
    .wdata (in_cell_value),
    .re    (accept),
    .raddr (col_cur),
    .rdata (mid_ram)
  );

  // Row two above: takes the row-above word once the cell is processed
  als_ram #(.WIDTH(als_pkg::CELL_W), .DEPTH(als_pkg::GRID_SIZE)) u_older_line (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (s1_col_r),
    .wdata (mid),
    .re    (accept),
    .raddr (col_cur),
    .rdata (top_ram)
  );

  // Forward the older word written in the same cycle it was read
  assign top = fwd_r ? fwd_data_r : top_ram;
  assign mid = mid_ram;

  // Advance the 3x3 window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_fire) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= s1_cell_r;
    end
  end

  // Count live neighbours
  always_comb begin
    neigh[0] = win_r[0];
    neigh[1] = win_r[1];
    neigh[2] = win_r[2];
    neigh[3] = win_r[3];
    neigh[4] = win_r[5];
    neigh[5] = top;
    neigh[6] = mid;
    neigh[7] = s1_cell_r;
    ncnt = '0;
    for (int i = 0; i < 8; i++) begin
      ncnt = ncnt + {{(als_pkg::NCNT_W-1){1'b0}}, (neigh[i] != '0)};
    end
  end

  // Apply the birth and survival rule to the centre cell
  assign centre = win_r[4];
  always_comb begin
    if (centre != '0) begin
      new_val = cfg.survive_mask[ncnt] ? centre - 1'b1 : '0;
    end else begin
      new_val = cfg.birth_mask[ncnt] ? cfg.live_value : '0;
    end
  end

  // Classify the position
  assign interior = (s1_row_r >= als_pkg::POS_TWO) && (s1_col_r >= als_pkg::POS_TWO);
  assign border   = (s1_row_r == '0) || (s1_row_r == als_pkg::POS_LAST) ||
                    (s1_col_r == '0) || (s1_col_r == als_pkg::POS_LAST);

  always_comb begin
    res_int.row    = als_pkg::pos_out(s1_row_r - 1'b1);
    res_int.col    = als_pkg::pos_out(s1_col_r - 1'b1);
    res_int.value  = new_val;
    res_int.last   = !border;
    res_bord.row   = als_pkg::pos_out(s1_row_r);
    res_bord.col   = als_pkg::pos_out(s1_col_r);
    res_bord.value = s1_cell_r;
    res_bord.last  = 1'b1;
  end

  // Drop results into the queue, interior one first
  always_comb begin
    push.a = interior ? res_int : res_bord;
    push.b = res_bord;
    push.n = s1_fire ? ({1'b0, interior} + {1'b0, border}) : 2'd0;
  end

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_full |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_row_r))
    else $error("held cell changed while stalled");

  a_fwd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_valid_r)
    else $error("forward flag set without a held cell");

endmodule

@@ sv/als_queue.sv @@
module als_queue (
  input  logic                           clk,
  input  logic                           rst_n,
  input  als_pkg::push_t                 push,
  output logic                           q_room,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [als_pkg::OUT_POS_W-1:0]  out_row,
  output logic [als_pkg::OUT_POS_W-1:0]  out_col,
  output logic [als_pkg::CELL_W-1:0]     out_new_value,
  output logic                           out_run_last
);

  als_pkg::res_t               q_r [als_pkg::Q_DEPTH];
  logic [als_pkg::QPTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [als_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        pop_fire;
  als_pkg::res_t               head;

  assign out_empty = (cnt_r == '0);
  assign pop_fire  = out_pop && !out_empty;
  assign q_room    = cnt_r <= als_pkg::QCNT_W'(als_pkg::Q_DEPTH - 2);

  assign wp_nxt  = wp_r + als_pkg::QPTR_W'(push.n);
  assign rp_nxt  = rp_r + als_pkg::QPTR_W'(pop_fire);
  assign cnt_nxt = cnt_r + als_pkg::QCNT_W'(push.n) - als_pkg::QCNT_W'(pop_fire);

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store one or two results per beat
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[wp_r] <= push.a;
    end
    if (push.n == 2'd2) begin
      q_r[wp_r + 1'b1] <= push.b;
    end
  end

  // Present the oldest result
  assign head          = q_r[rp_r];
  assign out_row       = head.row;
  assign out_col       = head.col;
  assign out_new_value = head.value;
  assign out_run_last  = head.last;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= als_pkg::QCNT_W'(als_pkg::Q_DEPTH))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push.n != 2'd0 |=> !out_empty)
    else $error("pushed result not visible");

endmodule

@@ sv/aging_life_automaton_step.sv @@
// Aging life-like automaton, one generation over a streamed square grid.
// Input channel: cells arrive in raster order on in_cell_value; raise
// in_frame_start with the first cell of a grid. A beat is taken when
// in_push is high and in_full is low. Output channel: while out_empty is
// low the oldest result (out_row, out_col, out_new_value, out_run_last)
// is shown; out_pop takes it. Configuration: cfg_we writes cfg_data into
// register cfg_index (0 birth mask, 1 survive mask, 2 live value); the
// user must write only while the block is idle, as the block does not
// enforce it. A border cell's result is held in the front stage, then
// written into the result queue; an interior cell's result follows once
// the cell one row and one column further on is taken. It takes one cell
// per cycle while in_full is low; most last-row and last-column cells give
// two results, so the single-result output port paces input there.
// Reset clears position counters, the neighbour window and the result
// queue and loads the default rule; the line buffers are not cleared.
// When the receiver stalls, the queue fills to three or four entries, a
// cell waits in the front part and in_full rises.
module aging_life_automaton_step (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [als_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [als_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [als_pkg::CELL_W-1:0]        in_cell_value,
  input  logic                              in_frame_start,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [als_pkg::OUT_POS_W-1:0]     out_row,
  output logic [als_pkg::OUT_POS_W-1:0]     out_col,
  output logic [als_pkg::CELL_W-1:0]        out_new_value,
  output logic                              out_run_last
);

  als_pkg::cfg_t  cfg_r;
  als_pkg::push_t push;
  logic           q_room;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.birth_mask   <= als_pkg::BIRTH_MASK_RST;
      cfg_r.survive_mask <= als_pkg::SURVIVE_MASK_RST;
      cfg_r.live_value   <= als_pkg::LIVE_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        als_pkg::REG_BIRTH_MASK:   cfg_r.birth_mask   <= cfg_data;
        als_pkg::REG_SURVIVE_MASK: cfg_r.survive_mask <= cfg_data;
        als_pkg::REG_LIVE_VALUE:   cfg_r.live_value   <= cfg_data[als_pkg::CELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  als_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_cell_value  (in_cell_value),
    .in_frame_start (in_frame_start),
    .q_room         (q_room),
    .push           (push)
  );

  als_queue u_queue (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .q_room        (q_room),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_new_value (out_new_value),
    .out_run_last  (out_run_last)
  );

endmodule

@@ tb/aging_life_automaton_step_tb.sv @@
`timescale 1ns / 1ps

module aging_life_automaton_step_tb;

  localparam int LAST_POS = als_pkg::GRID_SIZE - 1;

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [als_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [als_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic [als_pkg::CELL_W-1:0] in_cell_value = '0;
  logic in_frame_start = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [als_pkg::OUT_POS_W-1:0] out_row;
  logic [als_pkg::OUT_POS_W-1:0] out_col;
  logic [als_pkg::CELL_W-1:0] out_new_value;
  logic out_run_last;

  // Predictor copy of the rule and of the grid position, line buffers and window
  logic [als_pkg::MASK_W-1:0] rule_birth = als_pkg::BIRTH_MASK_RST;
  logic [als_pkg::MASK_W-1:0] rule_survive = als_pkg::SURVIVE_MASK_RST;
  logic [als_pkg::CELL_W-1:0] rule_lifetime = als_pkg::LIVE_VALUE_RST;
  int pos_row = 0;
  int pos_col = 0;
  logic [als_pkg::CELL_W-1:0] line_older [als_pkg::GRID_SIZE];
  logic [als_pkg::CELL_W-1:0] line_newer [als_pkg::GRID_SIZE];
  logic [als_pkg::CELL_W-1:0] nbr_win [6];

  // Results still owed by the block, oldest first
  als_pkg::res_t next_gen_q [$];
  als_pkg::res_t oldest_owed;

  // Idling controls and run statistics
  int tx_gap_pct = 15;
  int rx_stall_pct = 15;
  int hold_left = 0;
  int stall_left = 0;
  int mismatch_count = 0;
  int cells_sent = 0;
  int results_seen = 0;
  int rule_writes = 0;
  int full_cycles = 0;

  aging_life_automaton_step dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_push(in_push),
    .in_full(in_full),
    .in_cell_value(in_cell_value),
    .in_frame_start(in_frame_start),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_row(out_row),
    .out_col(out_col),
    .out_new_value(out_new_value),
    .out_run_last(out_run_last)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Work out the results one accepted beat causes and queue them
  function automatic void compute_next_gen(input logic [als_pkg::CELL_W-1:0] v, input bit fs);
    int r;
    int c;
    int cnt;
    bit inner;
    bit border;
    logic [als_pkg::CELL_W-1:0] top;
    logic [als_pkg::CELL_W-1:0] mid;
    logic [als_pkg::CELL_W-1:0] centre;
    logic [als_pkg::CELL_W-1:0] nv;
    als_pkg::res_t item;
    if (fs) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    top = line_older[c];
    mid = line_newer[c];
    inner = (r >= 2) && (c >= 2);
    border = (r == 0) || (r == LAST_POS) || (c == 0) || (c == LAST_POS);

    // The centre sits in the middle of the window; count the other eight
    if (inner) begin
      cnt = 0;
      for (int k = 0; k < 6; k++) begin
        if (k != 4 && nbr_win[k] != '0) cnt++;
      end
      if (top != '0) cnt++;
      if (mid != '0) cnt++;
      if (v != '0) cnt++;
      centre = nbr_win[4];
      if (centre != '0) nv = rule_survive[cnt] ? centre - 8'd1 : '0;
      else nv = rule_birth[cnt] ? rule_lifetime : '0;
      item.row = als_pkg::OUT_POS_W'(r - 1);
      item.col = als_pkg::OUT_POS_W'(c - 1);
      item.value = nv;
      item.last = !border;
      next_gen_q.push_back(item);
    end

    // Border cells go out unchanged
    if (border) begin
      item.row = als_pkg::OUT_POS_W'(r);
      item.col = als_pkg::OUT_POS_W'(c);
      item.value = v;
      item.last = 1'b1;
      next_gen_q.push_back(item);
    end

    // Shift the window and the line buffers, then advance the position
    nbr_win[0] = nbr_win[3];
    nbr_win[1] = nbr_win[4];
    nbr_win[2] = nbr_win[5];
    nbr_win[3] = top;
    nbr_win[4] = mid;
    nbr_win[5] = v;
    line_older[c] = mid;
    line_newer[c] = v;
    c++;
    if (c >= als_pkg::GRID_SIZE) begin
      c = 0;
      r++;
      if (r >= als_pkg::GRID_SIZE) r = 0;
    end
    pos_row = r;
    pos_col = c;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Live cells favour the extremes of the value range
  function automatic logic [als_pkg::CELL_W-1:0] pick_cell(input int density);
    if ($urandom_range(0, 99) >= density) return '0;
    case ($urandom_range(0, 4))
      0: return 8'd1;
      1: return 8'd255;
      default: return als_pkg::CELL_W'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 20)
      $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Hold the input channel idle with junk on the data ports
  task automatic pause_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_push <= 1'b0;
      in_cell_value <= als_pkg::CELL_W'($urandom);
      in_frame_start <= 1'($urandom_range(0, 1));
    end
  endtask

  // Offer one beat, wait for it to be taken, then maybe idle
  task automatic send_cell(input logic [als_pkg::CELL_W-1:0] value, input bit fs);
    @(negedge clk);
    in_push <= 1'b1;
    in_cell_value <= value;
    in_frame_start <= fs;
    @(posedge clk);
    while (in_full) @(posedge clk);
    compute_next_gen(value, fs);
    cells_sent++;
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) pause_input(pick_gap());
  endtask

  // Raster rows with the live density changing every sixteen cells
  task automatic send_rows(input int rows, input bit first_fs);
    int density;
    density = 0;
    for (int i = 0; i < rows * als_pkg::GRID_SIZE; i++) begin
      if (i % 16 == 0) begin
        case ($urandom_range(0, 4))
          0: density = 0;
          1: density = 10;
          2: density = 50;
          3: density = 90;
          default: density = 100;
        endcase
      end
      send_cell(pick_cell(density), first_fs && i == 0);
    end
  endtask

  // Wait until everything owed has come out, then let the pipeline empty
  task automatic settle_block();
    pause_input(1);
    while (next_gen_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [als_pkg::CFG_IDX_W-1:0] idx,
                           input logic [als_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      als_pkg::REG_BIRTH_MASK: rule_birth = data;
      als_pkg::REG_SURVIVE_MASK: rule_survive = data;
      als_pkg::REG_LIVE_VALUE: rule_lifetime = data[als_pkg::CELL_W-1:0];
      default: ;
    endcase
    rule_writes++;
  endtask

  task automatic set_rule(input logic [als_pkg::MASK_W-1:0] birth,
                          input logic [als_pkg::MASK_W-1:0] survive,
                          input logic [als_pkg::CELL_W-1:0] lifetime);
    write_reg(als_pkg::REG_BIRTH_MASK, birth);
    write_reg(als_pkg::REG_SURVIVE_MASK, survive);
    write_reg(als_pkg::REG_LIVE_VALUE, {1'b0, lifetime});
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // First row only: border pass-through at value extremes, with a restart mid-row
  task automatic test_border_values();
    logic [als_pkg::CELL_W-1:0] vals [20];
    vals = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd127, 8'd254, 8'd0, 8'd2, 8'h55, 8'hAA,
             8'd255, 8'd0, 8'd1, 8'd255, 8'd0, 8'h80, 8'h7F, 8'd3, 8'd0, 8'd255};
    for (int i = 0; i < 20; i++) send_cell(vals[i], i == 0 || i == 11);
    settle_block();
  endtask

  // Rule extremes: nothing lives, everything lives, births of zero
  task automatic test_rule_extremes();
    set_rule('0, '0, 8'd1);
    send_rows(3, 1'b1);
    settle_block();
    set_rule('1, '1, 8'd255);
    send_rows(3, 1'b1);
    settle_block();
    set_rule(als_pkg::BIRTH_MASK_RST, als_pkg::SURVIVE_MASK_RST, 8'd0);
    send_rows(3, 1'b1);
    settle_block();
  endtask

  // Stall the receiver on a run of border cells to fill the result queue, then restart
  task automatic test_backpressure_restart();
    set_rule(als_pkg::MASK_W'($urandom), als_pkg::MASK_W'($urandom),
             als_pkg::CELL_W'($urandom_range(1, 255)));
    hold_left = 80;
    for (int i = 0; i < 60; i++) send_cell(pick_cell(50), i == 0);
    send_rows(3, 1'b1);
    settle_block();
  endtask

  // Broken grids: frequent restarts at random points
  task automatic test_restart_noise();
    set_rule(als_pkg::MASK_W'($urandom), als_pkg::MASK_W'($urandom),
             als_pkg::CELL_W'($urandom_range(1, 255)));
    for (int i = 0; i < 120; i++)
      send_cell(als_pkg::CELL_W'($urandom), $urandom_range(0, 99) < 4);
    settle_block();
  endtask

  // Receiver: long hold when asked, otherwise random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
        stall_left = pick_gap() - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Check every beat taken from the result side against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && in_push && in_full) full_cycles++;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (next_gen_q.size() == 0) begin
        report_mismatch("result with nothing owed, row", -1, out_row);
      end else begin
        oldest_owed = next_gen_q.pop_front();
        if (out_row !== oldest_owed.row)
          report_mismatch("out_row", oldest_owed.row, out_row);
        if (out_col !== oldest_owed.col)
          report_mismatch("out_col", oldest_owed.col, out_col);
        if (out_new_value !== oldest_owed.value)
          report_mismatch("out_new_value", oldest_owed.value, out_new_value);
        if (out_run_last !== oldest_owed.last)
          report_mismatch("out_run_last", oldest_owed.last, out_run_last);
      end
    end
  end

  initial begin
    for (int i = 0; i < als_pkg::GRID_SIZE; i++) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    for (int i = 0; i < 6; i++) nbr_win[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_border_values();
    test_rule_extremes();
    test_backpressure_restart();
    test_restart_noise();

    settle_block();
    repeat (10) @(posedge clk);
    $display("sent %0d cells, checked %0d results over %0d register writes",
             cells_sent, results_seen, rule_writes);
    $display("input held off by a full result queue on %0d cycles", full_cycles);
    if (mismatch_count == 0 && next_gen_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatch_count, next_gen_q.size());
      $display("status: fail");
    end
    $finish;
  end

  // Give up well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout with %0d results still owed", next_gen_q.size());
    $display("status: fail");
    $finish;
  end

endmodule
